[src/u8d_pkg.sv]
// Shared types and constants for the UTF-8 to UCS-4 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_LEAD = 2'd1;
   localparam logic [1:0] ST_BAD_CONT = 2'd2;
   localparam logic [1:0] ST_TRUNC    = 2'd3;

   localparam int CP_W   = 31;
   localparam int LEN_W  = 3;
   localparam int ONES_W = 3;

   localparam logic [ONES_W-1:0] ONES_CONT    = 3'd1;
   localparam logic [ONES_W-1:0] ONES_INVALID = 3'd7;

   typedef struct packed {
      logic [7:0]        data;
      logic              last;
      logic [ONES_W-1:0] ones;
      logic              is_cont;
      logic [6:0]        lead_bits;
   } class_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic [1:0]       status;
   } result_type;

endpackage

`default_nettype wire

[src/u8d_front.sv]
// Front end: takes input bytes and classifies them by their leading ones.
`timescale 1ns / 1ps
`default_nettype none

module u8d_front
   import u8d_pkg::*;
(
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   output logic            push,
   output class_type       push_item,
   input  wire logic       queue_full
);

   logic [ONES_W-1:0] ones;
   logic [6:0]        mask;

   always_comb begin
      ones = ONES_INVALID;
      mask = 7'h00;
      if (!req_data_byte[7]) begin
         ones = 3'd0; mask = 7'h7f;
      end else if (!req_data_byte[6]) begin
         ones = 3'd1; mask = 7'h3f;
      end else if (!req_data_byte[5]) begin
         ones = 3'd2; mask = 7'h1f;
      end else if (!req_data_byte[4]) begin
         ones = 3'd3; mask = 7'h0f;
      end else if (!req_data_byte[3]) begin
         ones = 3'd4; mask = 7'h07;
      end else if (!req_data_byte[2]) begin
         ones = 3'd5; mask = 7'h03;
      end else if (!req_data_byte[1]) begin
         ones = 3'd6; mask = 7'h01;
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item.data      = req_data_byte;
      push_item.last      = req_final_byte;
      push_item.ones      = ones;
      push_item.is_cont   = (ones == ONES_CONT);
      push_item.lead_bits = req_data_byte[6:0] & mask;
   end

endmodule

`default_nettype wire

[src/u8d_queue.sv]
// Short queue of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue
   import u8d_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire class_type push_item,
   output logic           full,
   input  wire logic      pop,
   output logic           not_empty,
   output class_type      pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   class_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[src/u8d_back.sv]
// Back end: sequence state, code point assembly and the result register.
`timescale 1ns / 1ps
`default_nettype none

module u8d_back
   import u8d_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             item_valid,
   input  wire class_type        item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [CP_W-1:0]       rsp_code_point,
   output logic [LEN_W-1:0]      rsp_seq_length,
   output logic [1:0]            rsp_status
);

   logic [2:0]       pending_ff, pending_in;
   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_ff, out_in;
   result_type       res;
   logic             emit;
   logic [CP_W-1:0]  next_value;
   logic [2:0]       pending_dec;

   assign pop         = item_valid && (!out_valid_ff || rsp_ready);
   assign next_value  = {partial_ff[CP_W-7:0], item.data[5:0]};
   assign pending_dec = pending_ff - 3'd1;

   always_comb begin
      pending_in = pending_ff;
      partial_in = partial_ff;
      total_in   = total_ff;
      emit       = 1'b0;
      res        = '{code_point: '0, seq_length: '0, status: ST_OK};
      if (pending_ff == 3'd0) begin
         if (item.ones == 3'd0) begin
            emit = 1'b1;
            res  = '{code_point: CP_W'(item.lead_bits), seq_length: 3'd1, status: ST_OK};
         end else if (item.is_cont || item.ones == ONES_INVALID) begin
            emit = 1'b1;
            res.status = ST_BAD_LEAD;
         end else if (item.last) begin
            emit = 1'b1;
            res.status = ST_TRUNC;
         end else begin
            pending_in = item.ones - 3'd1;
            partial_in = CP_W'(item.lead_bits);
            total_in   = item.ones;
         end
      end else begin
         if (!item.is_cont) begin
            emit       = 1'b1;
            res.status = ST_BAD_CONT;
            pending_in = '0;
            partial_in = '0;
            total_in   = '0;
         end else if (pending_dec == 3'd0) begin
            emit       = 1'b1;
            res        = '{code_point: next_value, seq_length: total_ff, status: ST_OK};
            pending_in = '0;
            partial_in = '0;
            total_in   = '0;
         end else if (item.last) begin
            emit       = 1'b1;
            res.status = ST_TRUNC;
            pending_in = '0;
            partial_in = '0;
            total_in   = '0;
         end else begin
            pending_in = pending_dec;
            partial_in = next_value;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (pop && emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         partial_ff   <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
            total_ff   <= total_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_ff.code_point;
   assign rsp_seq_length = out_ff.seq_length;
   assign rsp_status     = out_ff.status;

endmodule

`default_nettype wire

[src/utf8_to_ucs4_decoder.sv]
// Top level of the UTF-8 to UCS-4 stream decoder.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data_byte[7:0], req_final_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_code_point[30:0], rsp_seq_length[2:0],
//                                            rsp_status[1:0]
//
// One byte a cycle sustained while the result register is not stalled; the sequence state
// update in the back end sets that figure. A result appears in the cycle after its last
// byte leaves the queue. Reset is synchronous and leaves the block idle. A stalled result
// register holds the back end; the queue then absorbs QUEUE_DEPTH items before req_ready
// falls.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_ucs4_decoder
   import u8d_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_final_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [CP_W-1:0]  rsp_code_point,
   output logic [LEN_W-1:0] rsp_seq_length,
   output logic [1:0]        rsp_status
);

   logic      push;
   class_type push_item;
   logic      queue_full;
   logic      pop;
   logic      queue_valid;
   class_type pop_item;

   u8d_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .push           (push),
      .push_item      (push_item),
      .queue_full     (queue_full)
   );

   u8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .pop_item  (pop_item)
   );

   u8d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (queue_valid),
      .item           (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point),
      .rsp_seq_length (rsp_seq_length),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire
